// ===== rtl/bmp_pixel_format_converter_core_macros.svh =====
// Assertion macros for the bitmap pixel converter checker.
// No dependencies; included by the checker file.
`ifndef BMP_PIXEL_FORMAT_CONVERTER_CORE_MACROS_SVH
`define BMP_PIXEL_FORMAT_CONVERTER_CORE_MACROS_SVH

`define BPFC_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("bpfc check failed");

`define BPFC_ASSERT_HOLD(lbl, clk, rstn, vld, rdy, sig) \
  `BPFC_ASSERT(lbl, clk, rstn, (vld && !rdy) |=> (vld && $stable(sig)))

`endif

// ===== rtl/bpfc_pkg.sv =====
// Shared codes and constants for the bitmap pixel converter.
// No dependencies; used by the core and its checker.
package bpfc_pkg;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;

  localparam logic FUNC_PIXEL   = 1'b0;
  localparam logic FUNC_PALETTE = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_BITS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_IS_16 = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd2;

  localparam logic [5:0] BPP_1  = 6'd1;
  localparam logic [5:0] BPP_2  = 6'd2;
  localparam logic [5:0] BPP_4  = 6'd4;
  localparam logic [5:0] BPP_8  = 6'd8;
  localparam logic [5:0] BPP_16 = 6'd16;
  localparam logic [5:0] BPP_24 = 6'd24;
  localparam logic [5:0] BPP_32 = 6'd32;

  localparam logic [5:0]  SOURCE_BITS_RST = BPP_8;
  localparam logic [12:0] IMAGE_WIDTH_RST = 13'd1;

endpackage

// ===== rtl/bmp_pixel_format_converter_core.sv =====
// Bitmap pixel converter core: takes one pixel-data byte or one palette write per word and
// emits RGB888 or RGB565 pixels. Palette writes and bytes that yield at most one pixel are
// taken at one word per cycle unless the output stalls; a byte that unpacks into several
// pixels holds the input until its last one issues, one palette lookup per cycle through the
// single palette RAM read port. A pixel passes the issue, palette-read and output registers.
// Depends on bpfc_pkg and bpfc_ram.
module bmp_pixel_format_converter_core
  import bpfc_pkg::*;
#(
  parameter int PALETTE_DEPTH = 256,
  parameter int MAX_WIDTH     = 4096
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  func_i,
  input  logic [7:0]            data_byte_i,
  input  logic [7:0]            palette_index_i,
  input  logic [31:0]           palette_color_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [31:0]           pixel_value_o,
  output logic                  last_of_run_o,
  output logic                  row_done_o
);

  localparam int AW    = $clog2(PALETTE_DEPTH);
  localparam int CNT_W = $clog2(MAX_WIDTH + 1);
  localparam int POS_W = $clog2(MAX_WIDTH * 4);
  localparam int LB_W  = CNT_W + 6;
  localparam logic [8:0]  PAL_LIMIT = 9'(PALETTE_DEPTH);
  localparam logic [13:0] MAXW      = 14'(MAX_WIDTH);

  function automatic logic [31:0] rgb888_to_565(input logic [31:0] c);
    rgb888_to_565 = {16'h0, c[23:19], c[15:10], c[7:3]};
  endfunction

  function automatic logic [31:0] rgb565_to_32(input logic [15:0] h);
    rgb565_to_32 = {11'h0, h[15:11], 2'h0, h[10:5], 3'h0, h[4:0]};
  endfunction

  logic [5:0]  source_bits_q;
  logic        output_is_16_q;
  logic [12:0] image_width_q;

  logic [POS_W-1:0] pos_q, pos_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [23:0]      partial_q, partial_d;
  logic [1:0]       phase_q, phase_d;

  logic             s0_valid_q, s0_valid_d;
  logic [31:0]      s0_word_q, s0_word_d;
  logic [2:0]       s0_left_q, s0_left_d;
  logic [CNT_W-1:0] s0_pix_q, s0_pix_d;

  logic        s1_valid_q, s1_pal_q, s1_oor_q, s1_src16_q, s1_last_q, s1_row_q;
  logic [31:0] s1_word_q;

  logic        out_valid_q, out_last_q, out_row_q;
  logic [31:0] out_pixel_q;

  logic             fmt_pal, fmt_dir, complete, pos_end, cfg_hit;
  logic             in_acc, pix_acc, pal_acc, s0_issue, s0_load, s1_en, out_load;
  logic [13:0]      width_ext;
  logic [CNT_W-1:0] w, rem;
  logic [LB_W-1:0]  w_lb, wb, row_bytes;
  logic [3:0]       slots, n;
  logic [31:0]      byte_shift, word_raw, word_dir, pal_rdata, conv_c, conv_v;
  logic [7:0]       pal_idx;

  assign fmt_pal = source_bits_q inside {BPP_1, BPP_2, BPP_4, BPP_8};
  assign fmt_dir = source_bits_q inside {BPP_16, BPP_24, BPP_32};
  assign cfg_hit = cfg_we_i && (cfg_idx_i inside {REG_SOURCE_BITS, REG_OUTPUT_IS_16,
                                                   REG_IMAGE_WIDTH});

  // effective row width and padded row length in bytes
  always_comb begin
    width_ext = {1'b0, image_width_q};
    if (width_ext == 14'd0) begin
      width_ext = 14'd1;
    end else if (width_ext > MAXW) begin
      width_ext = MAXW;
    end
    w    = width_ext[CNT_W-1:0];
    w_lb = LB_W'(w);
    case (source_bits_q)
      BPP_1:   wb = w_lb;
      BPP_2:   wb = w_lb << 1;
      BPP_4:   wb = w_lb << 2;
      BPP_8:   wb = w_lb << 3;
      BPP_16:  wb = w_lb << 4;
      BPP_24:  wb = (w_lb << 4) + (w_lb << 3);
      BPP_32:  wb = w_lb << 5;
      default: wb = '0;
    endcase
    row_bytes = ((wb + LB_W'(31)) >> 5) << 2;
  end

  assign in_acc  = in_valid_i && in_ready_o;
  assign pix_acc = in_acc && (func_i == FUNC_PIXEL);
  assign pal_acc = in_acc && (func_i == FUNC_PALETTE);
  assign rem     = w - cnt_q;
  assign pos_end = (LB_W'(pos_q) + LB_W'(1)) >= row_bytes;

  always_comb begin
    case (phase_q)
      2'd0:    byte_shift = {24'h0, data_byte_i};
      2'd1:    byte_shift = {16'h0, data_byte_i, 8'h0};
      2'd2:    byte_shift = {8'h0, data_byte_i, 16'h0};
      default: byte_shift = {data_byte_i, 24'h0};
    endcase
    word_raw = {8'h0, partial_q} | byte_shift;
    case (source_bits_q)
      BPP_16:  begin
        complete = phase_q >= 2'd1;
        word_dir = {16'h0, word_raw[15:0]};
      end
      BPP_24:  begin
        complete = phase_q >= 2'd2;
        word_dir = {8'h0, word_raw[23:0]};
      end
      default: begin
        complete = phase_q == 2'd3;
        word_dir = word_raw;
      end
    endcase
    case (source_bits_q)
      BPP_1:   slots = 4'd8;
      BPP_2:   slots = 4'd4;
      BPP_4:   slots = 4'd2;
      default: slots = 4'd1;
    endcase
    if (fmt_pal) begin
      n = (rem >= CNT_W'(slots)) ? slots : rem[3:0];
    end else if (fmt_dir) begin
      n = (complete && (rem != '0)) ? 4'd1 : 4'd0;
    end else begin
      n = 4'd0;
    end
  end

  // row position, pixel count and partial pixel
  always_comb begin
    pos_d     = pos_q;
    cnt_d     = cnt_q;
    partial_d = partial_q;
    phase_d   = phase_q;
    if (cfg_hit) begin
      pos_d     = '0;
      cnt_d     = '0;
      partial_d = '0;
      phase_d   = '0;
    end else if (pix_acc && (fmt_pal || fmt_dir)) begin
      cnt_d = cnt_q + CNT_W'(n);
      if (fmt_dir) begin
        if (complete) begin
          partial_d = '0;
          phase_d   = '0;
        end else begin
          partial_d = word_raw[23:0];
          phase_d   = phase_q + 2'd1;
        end
      end
      if (pos_end) begin
        pos_d     = '0;
        cnt_d     = '0;
        partial_d = '0;
        phase_d   = '0;
      end else begin
        pos_d = pos_q + POS_W'(1);
      end
    end
  end

  assign out_load   = s1_valid_q && (!out_valid_q || out_ready_i);
  assign s1_en      = !s1_valid_q || out_load;
  assign s0_issue   = s0_valid_q && s1_en;
  assign in_ready_o = !s0_valid_q || (s0_issue && (s0_left_q == 3'd0));
  assign s0_load    = pix_acc && (n != 4'd0);

  // issue stage: one pixel per cycle while the output does not stall
  always_comb begin
    s0_valid_d = s0_valid_q;
    s0_word_d  = s0_word_q;
    s0_left_d  = s0_left_q;
    s0_pix_d   = s0_pix_q;
    if (s0_load) begin
      s0_valid_d = 1'b1;
      s0_word_d  = fmt_dir ? word_dir : {24'h0, data_byte_i};
      s0_left_d  = 3'(n - 4'd1);
      s0_pix_d   = cnt_q;
    end else if (s0_issue) begin
      if (s0_left_q == 3'd0) begin
        s0_valid_d = 1'b0;
      end else begin
        s0_left_d = s0_left_q - 3'd1;
        s0_pix_d  = s0_pix_q + CNT_W'(1);
        case (source_bits_q)
          BPP_1:   s0_word_d = s0_word_q << 1;
          BPP_2:   s0_word_d = s0_word_q << 2;
          BPP_4:   s0_word_d = s0_word_q << 4;
          default: s0_word_d = s0_word_q;
        endcase
      end
    end
  end

  always_comb begin
    case (source_bits_q)
      BPP_1:   pal_idx = {7'h0, s0_word_q[7]};
      BPP_2:   pal_idx = {6'h0, s0_word_q[7:6]};
      BPP_4:   pal_idx = {4'h0, s0_word_q[7:4]};
      default: pal_idx = s0_word_q[7:0];
    endcase
  end

  bpfc_ram #(
    .WIDTH(32),
    .DEPTH(PALETTE_DEPTH)
  ) u_palette (
    .clk_i  (clk_i),
    .we_i   (pal_acc && ({1'b0, palette_index_i} < PAL_LIMIT)),
    .waddr_i(palette_index_i[AW-1:0]),
    .wdata_i(palette_color_i),
    .re_i   (s0_issue),
    .raddr_i(pal_idx[AW-1:0]),
    .rdata_o(pal_rdata)
  );

  always_comb begin
    if (s1_pal_q) begin
      conv_c = s1_oor_q ? 32'h0 : pal_rdata;
    end else begin
      conv_c = s1_word_q;
    end
    if (s1_src16_q) begin
      conv_v = output_is_16_q ? {16'h0, conv_c[15:0]} : rgb565_to_32(conv_c[15:0]);
    end else begin
      conv_v = output_is_16_q ? rgb888_to_565(conv_c) : conv_c;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      source_bits_q  <= SOURCE_BITS_RST;
      output_is_16_q <= 1'b0;
      image_width_q  <= IMAGE_WIDTH_RST;
      pos_q          <= '0;
      cnt_q          <= '0;
      partial_q      <= '0;
      phase_q        <= '0;
      s0_valid_q     <= 1'b0;
      s0_left_q      <= '0;
      s0_pix_q       <= '0;
      s1_valid_q     <= 1'b0;
      out_valid_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_SOURCE_BITS:  source_bits_q  <= cfg_wdata_i[5:0];
          REG_OUTPUT_IS_16: output_is_16_q <= cfg_wdata_i[0];
          REG_IMAGE_WIDTH:  image_width_q  <= cfg_wdata_i;
          default:          ;
        endcase
      end
      pos_q      <= pos_d;
      cnt_q      <= cnt_d;
      partial_q  <= partial_d;
      phase_q    <= phase_d;
      s0_valid_q <= s0_valid_d;
      s0_left_q  <= s0_left_d;
      s0_pix_q   <= s0_pix_d;
      if (s1_en) begin
        s1_valid_q <= s0_valid_q;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    s0_word_q <= s0_word_d;
    if (s1_en) begin
      s1_pal_q   <= fmt_pal;
      s1_oor_q   <= {1'b0, pal_idx} >= PAL_LIMIT;
      s1_src16_q <= source_bits_q == BPP_16;
      s1_word_q  <= s0_word_q;
      s1_last_q  <= s0_left_q == 3'd0;
      s1_row_q   <= (s0_pix_q + CNT_W'(1)) == w;
    end
    if (out_load) begin
      out_pixel_q <= conv_v;
      out_last_q  <= s1_last_q;
      out_row_q   <= s1_row_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign pixel_value_o = out_pixel_q;
  assign last_of_run_o = out_last_q;
  assign row_done_o    = out_row_q;

endmodule

// ===== rtl/bpfc_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module bpfc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/bpfc_checker.sv =====
// Port-level checks for the bitmap pixel converter core, bound to its top level.
// Depends on bpfc_pkg and bmp_pixel_format_converter_core_macros.svh.
`include "bmp_pixel_format_converter_core_macros.svh"

module bpfc_checker
  import bpfc_pkg::*;
(
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  cfg_we_i,
  input logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input logic                  out_valid_o,
  input logic                  out_ready_i,
  input logic [31:0]           pixel_value_o,
  input logic                  last_of_run_o,
  input logic                  row_done_o
);

  logic mode16_q;

  // track the output format from the configuration port
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode16_q <= 1'b0;
    end else if (cfg_we_i && (cfg_idx_i == REG_OUTPUT_IS_16)) begin
      mode16_q <= cfg_wdata_i[0];
    end
  end

  `BPFC_ASSERT_HOLD(a_out_hold, clk_i, rst_ni, out_valid_o, out_ready_i, pixel_value_o)
  `BPFC_ASSERT(a_row_end_last, clk_i, rst_ni, (out_valid_o && row_done_o) |-> last_of_run_o)
  `BPFC_ASSERT(a_565_upper_zero, clk_i, rst_ni, (out_valid_o && mode16_q) |-> (pixel_value_o[31:16] == 16'h0))

endmodule

bind bmp_pixel_format_converter_core bpfc_checker u_bpfc_checker (.*);
